### src/rcsp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcsp_pkg
// Shared widths, reset values, register indexes and angle mapping constants
// for the RC servo pulse reader.
// ----------------------------------------------------------------------------
package rcsp_pkg;

    // field widths
    localparam int WIDTH_W   = 12;
    localparam int TIMEOUT_W = 17;
    localparam int ANGLE_W   = 11;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 17;

    // width counter saturation default
    localparam int WIDTH_COUNTER_MAX_DEF = 4095;

    // since-valid counter saturates at all ones
    localparam logic [TIMEOUT_W-1:0] SINCE_VALID_MAX = '1;

    // register reset values
    localparam logic [WIDTH_W-1:0]   MIN_WIDTH_RST = 12'd200;
    localparam logic [WIDTH_W-1:0]   MAX_WIDTH_RST = 12'd2800;
    localparam logic [TIMEOUT_W-1:0] TIMEOUT_RST   = 17'd25000;

    // register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MIN_WIDTH = 2'd0,
        CFG_MAX_WIDTH = 2'd1,
        CFG_TIMEOUT   = 2'd2
    } t_cfg_idx;

    // angle = trunc((w - 1000) * 180 / 1000) = trunc((w - 1000) * 9 / 50)
    // the divide by 50 is a multiply by ceil(2^27 / 50), folded with the 9
    localparam int                 ANGLE_OFFSET = 1000;
    localparam int                 ANGLE_SHIFT  = 27;
    localparam int                 RECIP_W      = 25;
    localparam logic [RECIP_W-1:0] ANGLE_RECIP  = 25'd24159195;

endpackage

### src/rc_servo_pulse_reader_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rc_servo_pulse_reader_top
// Measures the high time of an RC servo pulse from one pin sample per
// microsecond tick and reports presence, held width and mapped angle.
// ----------------------------------------------------------------------------
// Each accepted request is one pin sample. The block returns exactly one
// result per sample, through a middle and an output register, and takes a new
// sample every cycle while the output is not stalled: the first register stage
// updates the edge detector, the saturating counters and the held width, the
// second maps the held width to degrees with one constant multiply. Widths
// strictly between min_width_us and max_width_us are held; anything else, a
// fall with no counted rise, or more than timeout_us ticks since the last good
// pulse drops the signal, and then width and angle read 0. Registers may be
// written at any time through the configuration channel, which is always
// ready; index 3 is ignored.
module rc_servo_pulse_reader_top #(
    parameter int WIDTH_COUNTER_MAX = rcsp_pkg::WIDTH_COUNTER_MAX_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // sample channel
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  logic                             i_pin_level,
    // result channel
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic                             o_signal_present,
    output logic [rcsp_pkg::WIDTH_W-1:0]     o_pulse_width_us,
    output logic signed [rcsp_pkg::ANGLE_W-1:0] o_angle_deg,
    // configuration channel
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [rcsp_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [rcsp_pkg::CFG_DAT_W-1:0]   i_cfg_data
);
    import rcsp_pkg::*;

    localparam int CW   = $clog2(WIDTH_COUNTER_MAX + 1);
    localparam int CMPW = (CW > WIDTH_W) ? CW : WIDTH_W;
    localparam logic [CW-1:0] RISE_MAX = CW'(WIDTH_COUNTER_MAX);

    // configuration registers
    logic [WIDTH_W-1:0]   r_min_width;
    logic [WIDTH_W-1:0]   r_max_width;
    logic [TIMEOUT_W-1:0] r_timeout;

    // tracking state
    logic                 r_prev_level;
    logic [CW-1:0]        r_since_rise;
    logic [TIMEOUT_W-1:0] r_since_valid;
    logic [WIDTH_W-1:0]   r_held_width;
    logic                 r_held_valid;

    // middle stage
    logic                 r_p_valid;
    logic                 r_p_present;
    logic [WIDTH_W-1:0]   r_p_width;

    // output stage
    logic                 r_out_valid;
    logic                 r_out_present;
    logic [WIDTH_W-1:0]   r_out_width;
    logic signed [ANGLE_W-1:0] r_out_angle;

    logic                 adv;
    logic                 in_acc;
    logic [CW-1:0]        rise_inc;
    logic [TIMEOUT_W-1:0] valid_inc;
    logic                 is_rise;
    logic                 is_fall;
    logic [CMPW-1:0]      w_ext;
    logic                 w_ok;
    logic                 accepted;
    logic [CW-1:0]        n_since_rise;
    logic [TIMEOUT_W-1:0] n_since_valid;
    logic [WIDTH_W-1:0]   n_held_width;
    logic                 n_held_valid;

    logic signed [WIDTH_W:0]          diff;
    logic                             diff_neg;
    logic [WIDTH_W-1:0]               diff_abs;
    logic [WIDTH_W+RECIP_W-1:0]       prod;
    logic [ANGLE_W-1:0]               quot;
    logic signed [ANGLE_W-1:0]        n_angle;

    // handshakes
    assign adv         = !r_out_valid || i_out_ready;
    assign o_in_ready  = !r_p_valid || adv;
    assign in_acc      = i_in_valid && o_in_ready;
    assign o_cfg_ready = 1'b1;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_width <= MIN_WIDTH_RST;
            r_max_width <= MAX_WIDTH_RST;
            r_timeout   <= TIMEOUT_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_MIN_WIDTH: r_min_width <= i_cfg_data[WIDTH_W-1:0];
                CFG_MAX_WIDTH: r_max_width <= i_cfg_data[WIDTH_W-1:0];
                CFG_TIMEOUT:   r_timeout   <= i_cfg_data[TIMEOUT_W-1:0];
                default: ;
            endcase
        end
    end

    // per-tick update: advance counters, handle edges, check timeout
    always_comb begin
        rise_inc  = (r_since_rise < RISE_MAX) ? r_since_rise + 1'b1 : r_since_rise;
        valid_inc = (r_since_valid != SINCE_VALID_MAX) ? r_since_valid + 1'b1
                                                       : r_since_valid;
        is_rise   = i_pin_level && !r_prev_level;
        is_fall   = !i_pin_level && r_prev_level;
        w_ext     = CMPW'(rise_inc);
        w_ok      = (rise_inc < RISE_MAX)
                 && (w_ext > CMPW'(r_min_width))
                 && (w_ext < CMPW'(r_max_width));
        accepted  = is_fall && w_ok;

        n_since_rise  = is_rise ? '0 : rise_inc;
        n_since_valid = accepted ? '0 : valid_inc;
        n_held_width  = r_held_width;
        n_held_valid  = r_held_valid;
        if (is_fall) begin
            n_held_valid = w_ok;
            n_held_width = w_ok ? w_ext[WIDTH_W-1:0] : '0;
        end
        if (!accepted && (valid_inc > r_timeout)) begin
            n_held_valid = 1'b0;
            n_held_width = '0;
        end
    end

    // tracking state and middle stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_level  <= 1'b0;
            r_since_rise  <= RISE_MAX;
            r_since_valid <= SINCE_VALID_MAX;
            r_held_width  <= '0;
            r_held_valid  <= 1'b0;
            r_p_valid     <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_p_valid <= i_in_valid;
            end
            if (in_acc) begin
                r_prev_level  <= i_pin_level;
                r_since_rise  <= n_since_rise;
                r_since_valid <= n_since_valid;
                r_held_width  <= n_held_width;
                r_held_valid  <= n_held_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_p_present <= n_held_valid;
            r_p_width   <= n_held_width;
        end
    end

    // angle mapping, truncated toward zero
    always_comb begin
        diff     = $signed({1'b0, r_p_width}) - (WIDTH_W+1)'(ANGLE_OFFSET);
        diff_neg = diff[WIDTH_W];
        diff_abs = diff_neg ? WIDTH_W'(-diff) : diff[WIDTH_W-1:0];
        prod     = (WIDTH_W+RECIP_W)'(diff_abs) * (WIDTH_W+RECIP_W)'(ANGLE_RECIP);
        quot     = ANGLE_W'(prod >> ANGLE_SHIFT);
        if (!r_p_present) begin
            n_angle = '0;
        end else if (diff_neg) begin
            n_angle = -$signed(quot);
        end else begin
            n_angle = $signed(quot);
        end
    end

    // output stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= r_p_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && r_p_valid) begin
            r_out_present <= r_p_present;
            r_out_width   <= r_p_width;
            r_out_angle   <= n_angle;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_signal_present = r_out_present;
    assign o_pulse_width_us = r_out_width;
    assign o_angle_deg      = r_out_angle;

endmodule
